// ===== sv/stpll_pkg.sv =====
package stpll_pkg;

  localparam int unsigned FreqW = 22;
  localparam int unsigned BandCount = 11;
  localparam int unsigned IdxW = 4;
  localparam int unsigned ProdW = 25;
  localparam int unsigned RecipW = 26;
  localparam int unsigned RecipShift = 39;
  localparam int unsigned QuotW = 12;

  typedef logic [FreqW-1:0] freq_t;
  typedef logic [IdxW-1:0] band_idx_t;
  typedef logic [31:0] word_t;
  typedef logic [1:0] word_sel_t;

  localparam freq_t FreqMin = 22'd950000;
  localparam freq_t FreqMax = 22'd2150000;
  localparam longint unsigned RefDiv = 64'd10111;

  // ceil(2^39 / 10111); exact floor quotient for any dividend below 2^25
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'(((64'd1 << RecipShift) + RefDiv - 64'd1) / RefDiv);

  localparam word_t PllBase  = 32'hf800_0000;
  localparam word_t GainWord1 = 32'h500c_0000;
  localparam word_t GainWord2 = 32'h83f1_f800;

  localparam word_sel_t WordBand  = 2'd0;
  localparam word_sel_t WordGain1 = 2'd1;
  localparam word_sel_t WordGain2 = 2'd2;
  localparam word_sel_t WordPll   = 2'd3;

  localparam logic [1:0] PumpLow  = 2'd1;
  localparam logic [1:0] PumpHigh = 2'd2;

  localparam freq_t BandEdge [0:BandCount-1] = '{
    22'd950000,  22'd1019000, 22'd1075000, 22'd1178000, 22'd1296000, 22'd1432000,
    22'd1576000, 22'd1718000, 22'd1856000, 22'd2036000, 22'd2150000
  };

  localparam word_t BandWord [0:BandCount-1] = '{
    32'h0000_0000, 32'h0002_0000, 32'h0004_0000, 32'h0010_0800, 32'h0010_1000,
    32'h0010_2000, 32'h0010_4000, 32'h0010_8000, 32'h0011_0000, 32'h0012_0000,
    32'h0014_0000
  };

endpackage

// ===== sv/satellite_tuner_pll_word_calc_unit.sv =====
// The first word (band select) is valid once the item has passed stages 1 to 3 and been loaded into the output stage.
// Item rate is bounded by the four-word output serializer, which stalls while m_axis_tready is low; a new item
// is taken while words go out, and the 3-stage front end keeps the next item ready so words go out back to back.
// Per item: clamp/band pick/scale, reciprocal multiply, then split into PLL fields.
// rst (synchronous, active high) empties all stages; payload registers are not reset.
module satellite_tuner_pll_word_calc_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [21:0] freq_khz, [23:22] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] tuner_word
  output logic        m_axis_tlast   // last_word
);

  // stage 1: input register
  logic                  v1;
  stpll_pkg::freq_t      freq1;
  // stage 2: scaled dividend, band, pump
  logic                  v2;
  logic [stpll_pkg::ProdW-1:0] dvd2;
  stpll_pkg::band_idx_t  idx2;
  logic [1:0]            pump2;
  // stage 3: reciprocal product
  logic                  v3;
  logic [stpll_pkg::ProdW+stpll_pkg::RecipW-1:0] prod3;
  stpll_pkg::band_idx_t  idx3;
  logic [1:0]            pump3;
  // output stage
  logic                  ov;
  stpll_pkg::word_sel_t  sel;
  stpll_pkg::word_t      band_word;
  stpll_pkg::word_t      pll_word;

  logic rdy1, rdy2, rdy3, ld_out, out_take;

  assign out_take = ov && m_axis_tready;
  assign ld_out   = v3 && (!ov || (out_take && sel == stpll_pkg::WordPll));
  assign rdy3     = !v3 || ld_out;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  // clamp, band search, pump, dividend
  stpll_pkg::freq_t      fc;
  stpll_pkg::band_idx_t  idx_c;
  logic [stpll_pkg::FreqW:0] mid_c;
  logic [stpll_pkg::ProdW-1:0] f10;
  logic [stpll_pkg::ProdW-1:0] dvd_c;
  logic [1:0]            pump_c;

  always_comb begin
    if (freq1 < stpll_pkg::FreqMin) begin
      fc = stpll_pkg::FreqMin;
    end else if (freq1 > stpll_pkg::FreqMax) begin
      fc = stpll_pkg::FreqMax;
    end else begin
      fc = freq1;
    end
    // smallest band whose upper edge is not below the frequency
    idx_c = stpll_pkg::band_idx_t'(stpll_pkg::BandCount - 1);
    for (int i = stpll_pkg::BandCount - 1; i >= 1; i--) begin
      if (stpll_pkg::BandEdge[i] >= fc) begin
        idx_c = stpll_pkg::band_idx_t'(i);
      end
    end
    mid_c = ({1'b0, stpll_pkg::BandEdge[idx_c - 4'd1]} +
             {1'b0, stpll_pkg::BandEdge[idx_c]}) >> 1;
    pump_c = ({1'b0, fc} < mid_c) ? stpll_pkg::PumpLow : stpll_pkg::PumpHigh;
    f10 = (stpll_pkg::ProdW'(fc) << 3) + (stpll_pkg::ProdW'(fc) << 1);
    // two lowest bands run the VCO at double rate
    dvd_c = (idx_c <= 4'd2) ? (f10 << 1) : f10;
  end

  // quotient split at output load
  logic [stpll_pkg::QuotW-1:0] quot;
  logic [4:0]            swallow;
  logic [8:0]            mainc;

  always_comb begin
    quot    = prod3[stpll_pkg::RecipShift +: stpll_pkg::QuotW];
    swallow = quot[4:0];
    mainc   = {2'b00, quot[stpll_pkg::QuotW-1:5]} - {8'd0, (swallow == 5'd0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      ov  <= 1'b0;
      sel <= stpll_pkg::WordBand;
    end else begin
      if (rdy1) begin
        v1 <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (ld_out) begin
        ov  <= 1'b1;
        sel <= stpll_pkg::WordBand;
      end else if (out_take) begin
        if (sel == stpll_pkg::WordPll) begin
          ov <= 1'b0;
        end
        sel <= sel + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      freq1 <= s_axis_tdata[stpll_pkg::FreqW-1:0];
    end
    if (rdy2) begin
      dvd2  <= dvd_c;
      idx2  <= idx_c;
      pump2 <= pump_c;
    end
    if (rdy3) begin
      prod3 <= dvd2 * stpll_pkg::RecipMul;
      idx3  <= idx2;
      pump3 <= pump2;
    end
    if (ld_out) begin
      band_word <= stpll_pkg::BandWord[idx3];
      pll_word  <= stpll_pkg::PllBase | (32'(pump3) << 25) | (32'(mainc) << 16) |
                   (32'(swallow) << 11);
    end
  end

  always_comb begin
    case (sel)
      stpll_pkg::WordBand:  m_axis_tdata = band_word;
      stpll_pkg::WordGain1: m_axis_tdata = stpll_pkg::GainWord1;
      stpll_pkg::WordGain2: m_axis_tdata = stpll_pkg::GainWord2;
      default:              m_axis_tdata = pll_word;
    endcase
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tlast  = (sel == stpll_pkg::WordPll);

  // PLL word: fixed top bits and exactly one pump bit set
  a_pll_fmt: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[31:27] == 5'h1f && (m_axis_tdata[26] != m_axis_tdata[25]))
    else $error("malformed PLL word");

  // words of a run go out in order without a gap in validity
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && sel == $past(sel) + 2'd1)
    else $error("output run broken");

  // run ends empty when nothing waits behind it
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast && !v3 |=> !m_axis_tvalid)
    else $error("output valid after last word with no item pending");

  // a new run always starts at the band word
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    ld_out |=> m_axis_tvalid && sel == stpll_pkg::WordBand)
    else $error("run did not start at band word");

endmodule

// ===== verif/tuner_word_checker.sv =====
module tuner_word_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          words_pending,
  output int          mismatch_count
);

  localparam int unsigned MainMask    = 32'h1ff;
  localparam int unsigned SwallowMask = 32'h1f;

  typedef struct {
    stpll_pkg::word_t word;
    logic             last;
  } tuner_beat_t;

  tuner_beat_t expected_words [$];
  int          fails = 0;

  // Queue the four words one tuning request must produce.
  task automatic queue_tuning_words(input stpll_pkg::freq_t req);
    stpll_pkg::freq_t     f;
    stpll_pkg::band_idx_t band;
    int unsigned          factor, quot, swallow, main_cnt, edge_lo, edge_hi;
    longint unsigned      prod;
    logic [1:0]           pump;
    stpll_pkg::word_t     pll;
    f = req;
    if (f < stpll_pkg::FreqMin) f = stpll_pkg::FreqMin;
    if (f > stpll_pkg::FreqMax) f = stpll_pkg::FreqMax;
    band = stpll_pkg::band_idx_t'(1);
    while (band < stpll_pkg::BandCount && stpll_pkg::BandEdge[band] < f) band++;
    if (band >= stpll_pkg::BandCount) band = stpll_pkg::band_idx_t'(stpll_pkg::BandCount - 1);
    factor   = (band <= 2) ? 2 : 1;
    prod     = longint'(factor) * longint'(f) * 64'd10;
    quot     = int'(prod / stpll_pkg::RefDiv);
    swallow  = quot % 32;
    main_cnt = quot / 32;
    if (swallow == 0) main_cnt = main_cnt - 1;
    // midpoint sum is formed in 32-bit int before halving
    edge_lo = stpll_pkg::BandEdge[band - 1];
    edge_hi = stpll_pkg::BandEdge[band];
    pump = (int'(f) < (edge_lo + edge_hi) / 2) ? stpll_pkg::PumpLow : stpll_pkg::PumpHigh;
    pll = stpll_pkg::PllBase | (stpll_pkg::word_t'(pump) << 25) |
          (stpll_pkg::word_t'(main_cnt & MainMask) << 16) |
          (stpll_pkg::word_t'(swallow & SwallowMask) << 11);
    expected_words.push_back('{word: stpll_pkg::BandWord[band], last: 1'b0});
    expected_words.push_back('{word: stpll_pkg::GainWord1, last: 1'b0});
    expected_words.push_back('{word: stpll_pkg::GainWord2, last: 1'b0});
    expected_words.push_back('{word: pll, last: 1'b1});
  endtask

  always @(posedge clk) begin
    tuner_beat_t exp_word;
    if (rst) begin
      expected_words.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        queue_tuning_words(stpll_pkg::freq_t'(s_axis_tdata[21:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("tuner_word: expected none, got %h", m_axis_tdata);
          fails++;
        end else begin
          exp_word = expected_words.pop_front();
          if (m_axis_tdata !== exp_word.word) begin
            $error("tuner_word: expected %h, got %h", exp_word.word, m_axis_tdata);
            fails++;
          end
          if (m_axis_tlast !== exp_word.last) begin
            $error("last_word: expected %b, got %b", exp_word.last, m_axis_tlast);
            fails++;
          end
        end
      end
    end
    words_pending  <= expected_words.size();
    mismatch_count <= fails;
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;

  localparam int StallLimit = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  int words_pending;
  int mismatch_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  satellite_tuner_pll_word_calc_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  tuner_word_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .words_pending  (words_pending),
    .mismatch_count (mismatch_count)
  );

  // Output side: random stalls, plus a long hold-off whenever hold_seq moves.
  always @(posedge clk) begin
    int hold_left;
    int hold_ack;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      hold_ack  = 0;
    end else if (hold_seq != hold_ack) begin
      hold_ack  = hold_seq;
      hold_left = hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called in the step of a rising edge; returns in the step the item is taken.
  task automatic send_freq(input stpll_pkg::freq_t f);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, f};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (words_pending != 0);
  endtask

  // Mostly in range, some near band edges, some any 22-bit value.
  function automatic stpll_pkg::freq_t pick_freq();
    int unsigned r;
    int          k;
    r = $urandom_range(99);
    if (r < 15) return stpll_pkg::freq_t'($urandom);
    if (r < 30) begin
      k = $urandom_range(stpll_pkg::BandCount - 1);
      return stpll_pkg::freq_t'(int'(stpll_pkg::BandEdge[k]) + int'($urandom_range(4)) - 2);
    end
    return stpll_pkg::freq_t'($urandom_range(stpll_pkg::FreqMax, stpll_pkg::FreqMin));
  endfunction

  initial begin
    stpll_pkg::freq_t directed [$];
    directed = '{
      22'd0, 22'h3fffff, stpll_pkg::FreqMin - 22'd1, stpll_pkg::FreqMin,
      stpll_pkg::FreqMax, stpll_pkg::FreqMax + 22'd1,
      stpll_pkg::BandEdge[1], stpll_pkg::BandEdge[1] + 22'd1,
      stpll_pkg::BandEdge[2], stpll_pkg::BandEdge[2] + 22'd1,
      22'd984499, 22'd984500, 22'd1363999, 22'd1364000,
      22'd970656, 22'd1100077, 22'd2070733,  // swallow count of zero
      stpll_pkg::BandEdge[9], stpll_pkg::BandEdge[9] + 22'd1, 22'h155555, 22'h2aaaaa
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_freq(directed[i]);

    // long output hold while input keeps coming: block fills and backs up
    hold_len <= 60;
    hold_seq <= hold_seq + 1;
    repeat (12) send_freq(pick_freq());
    s_axis_tvalid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 62; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 62; end
        default: begin idle_pct = 26; stall_pct <= 26; end
      endcase
      repeat (22) send_freq(pick_freq());
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
